// ===== hdl/rpc_pkg.sv =====
// Shared types and constants for the RC pulse-width capture block.
// Used by the channel interfaces, the register file, the width datapath and the top level.
package rpc_pkg;

  // Field widths fixed by the event and result formats
  localparam int CHAN_W  = 2;
  localparam int FIELD_W = 16;
  localparam int WRAP_W  = 17;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF   = 4;
  localparam int STAMP_BITS_DEF = 16;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int ADDR_W = 4;
  localparam int REG_IDX_W = 2;

  // Register reset values
  localparam logic [WRAP_W-1:0]  WRAP_RESET   = 17'd10000;
  localparam logic [FIELD_W-1:0] JUMP_RESET   = 16'd500;
  localparam logic [FIELD_W-1:0] THRESH_RESET = 16'd1600;
  localparam logic [FIELD_W-1:0] SETTLE_RESET = 16'd0;

  // Per-channel width after reset
  localparam logic [FIELD_W-1:0] WIDTH_RESET = 16'd1500;

  // Register map, word index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WRAP   = 2'd0,
    REG_JUMP   = 2'd1,
    REG_THRESH = 2'd2,
    REG_SETTLE = 2'd3
  } reg_idx_t;

  // Current register contents, handed to the datapath
  typedef struct packed {
    logic [WRAP_W-1:0]  wrap_period;
    logic [FIELD_W-1:0] jump_limit;
    logic [FIELD_W-1:0] activate_threshold;
    logic [FIELD_W-1:0] settle_delay;
  } cfg_t;

  // Width datapath result
  typedef struct packed {
    logic               accept;
    logic [FIELD_W-1:0] width;
  } calc_res_t;

endpackage

// ===== hdl/rpc_ifs.sv =====
// Valid/ready channel interfaces for capture events and decoded results.
// Depends on rpc_pkg for field widths.
interface rpc_in_if;
  import rpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  chan;
  logic [FIELD_W-1:0] stamp;
  logic [FIELD_W-1:0] settle_count;

  modport source (output valid, chan, stamp, settle_count, input ready);
  modport sink   (input valid, chan, stamp, settle_count, output ready);
endinterface

interface rpc_out_if;
  import rpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  out_chan;
  logic               width_valid;
  logic [FIELD_W-1:0] pulse_width;
  logic               remote_on;
  logic               remote_claim;

  modport source (output valid, out_chan, width_valid, pulse_width, remote_on, remote_claim,
                  input ready);
  modport sink   (input valid, out_chan, width_valid, pulse_width, remote_on, remote_claim,
                  output ready);
endinterface

// ===== hdl/rpc_cfg_regs.sv =====
// APB-style configuration registers: wrap period, jump limit, threshold, settle delay.
// Depends on rpc_pkg for the register map and reset values.
module rpc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpc_pkg::APB_DW-1:0]   pwdata,
  output logic [rpc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output rpc_pkg::cfg_t                cfg
);
  import rpc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[REG_IDX_W+1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_period        <= WRAP_RESET;
      cfg_r.jump_limit         <= JUMP_RESET;
      cfg_r.activate_threshold <= THRESH_RESET;
      cfg_r.settle_delay       <= SETTLE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_WRAP:   cfg_r.wrap_period        <= pwdata[WRAP_W-1:0];
        REG_JUMP:   cfg_r.jump_limit         <= pwdata[FIELD_W-1:0];
        REG_THRESH: cfg_r.activate_threshold <= pwdata[FIELD_W-1:0];
        REG_SETTLE: cfg_r.settle_delay       <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_WRAP:   prdata = APB_DW'(cfg_r.wrap_period);
      REG_JUMP:   prdata = APB_DW'(cfg_r.jump_limit);
      REG_THRESH: prdata = APB_DW'(cfg_r.activate_threshold);
      REG_SETTLE: prdata = APB_DW'(cfg_r.settle_delay);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/rpc_width_calc.sv =====
// Pulse width from rise/fall stamps with wrap correction, glitch filter and clamp.
// Depends on rpc_pkg for widths and the result struct.
module rpc_width_calc #(
  parameter int STAMP_W = rpc_pkg::FIELD_W
) (
  input  logic [STAMP_W-1:0]          fall_stamp,
  input  logic [STAMP_W-1:0]          rise_stamp,
  input  logic [rpc_pkg::FIELD_W-1:0] last_width,
  input  logic [rpc_pkg::WRAP_W-1:0]  wrap_period,
  input  logic [rpc_pkg::FIELD_W-1:0] jump_limit,
  output rpc_pkg::calc_res_t          res
);
  import rpc_pkg::*;

  // signed working width: covers -2^16 .. 2^17 plus the filter difference
  localparam int DW = WRAP_W + 2;

  logic signed [DW-1:0] w;
  logic signed [DW-1:0] diff;
  logic        [DW-1:0] diff_abs;
  logic                 wrapped;

  always_comb begin
    wrapped = fall_stamp < rise_stamp;
    w = $signed({{(DW-STAMP_W){1'b0}}, fall_stamp})
      - $signed({{(DW-STAMP_W){1'b0}}, rise_stamp});
    if (wrapped) begin
      w = w + $signed({{(DW-WRAP_W){1'b0}}, wrap_period});
    end
    diff     = w - $signed({{(DW-FIELD_W){1'b0}}, last_width});
    diff_abs = diff[DW-1] ? DW'(-diff) : DW'(diff);
    res.accept = diff_abs <= {{(DW-FIELD_W){1'b0}}, jump_limit};

    // clamp to the field range
    if (w[DW-1]) begin
      res.width = '0;
    end else if (w > $signed({{(DW-FIELD_W){1'b0}}, {FIELD_W{1'b1}}})) begin
      res.width = {FIELD_W{1'b1}};
    end else begin
      res.width = w[FIELD_W-1:0];
    end
  end

endmodule

// ===== hdl/rc_pulse_width_capture.sv =====
// RC pulse-width capture decoder, top level.
// Depends on rpc_pkg, rpc_ifs, rpc_cfg_regs and rpc_width_calc.
//
// in_w carries capture events (chan, stamp, settle_count); out_w carries one
// result word per event (out_chan, width_valid, pulse_width, remote_on,
// remote_claim). Per channel, events alternate rising/falling: a rising edge
// stores its stamp, a falling edge yields the filtered width. Remote mode
// latches on once channel 1's stored width exceeds the threshold and the
// settle count has reached the settle delay, checked before the event.
// Registers are written through the cfg_ APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
//
// An accepted word sits in the input register; the per-channel
// read-modify-write and the result register load happen together when it
// advances, which it does when the result register is free or being drained.
// Throughput: one word per cycle while out_w.ready stays high. Reset clears
// all channels to "expect rising edge", widths to 1500, remote mode off, and
// the registers to their defaults. When out_w.ready is low the result holds,
// the input register still takes one more word, then in_w stalls.
module rc_pulse_width_capture #(
  parameter int CHANNELS   = rpc_pkg::CHANNELS_DEF,
  parameter int STAMP_BITS = rpc_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rpc_in_if.sink                       in_w,
  rpc_out_if.source                    out_w,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [rpc_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [rpc_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import rpc_pkg::*;

  localparam int SB    = (STAMP_BITS < FIELD_W) ? STAMP_BITS : FIELD_W;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CX_W  = 5;

  cfg_t      cfg;
  calc_res_t calc;

  // input register
  logic               s1_v_r;
  logic [CHAN_W-1:0]  s1_chan_r;
  logic [SB-1:0]      s1_stamp_r;
  logic [FIELD_W-1:0] s1_settle_r;

  // per-channel state
  logic               awaiting_r [CHANNELS];
  logic [SB-1:0]      rise_r     [CHANNELS];
  logic [FIELD_W-1:0] last_r     [CHANNELS];
  logic               remote_r;

  // result register
  logic               out_v_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic               out_wv_r;
  logic [FIELD_W-1:0] out_width_r;
  logic               out_on_r;
  logic               out_claim_r;

  logic               adv;
  logic [CX_W-1:0]    chan_ext;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [FIELD_W-1:0] ch1_width;
  logic               claim;
  logic               fall_evt;
  logic [FIELD_W-1:0] width_nxt;
  logic [FIELD_W-1:0] cur_last;
  logic [SB-1:0]      cur_rise;

  rpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // handshake: advance when the result register is free or being drained
  assign adv        = s1_v_r && (!out_v_r || out_w.ready);
  assign in_w.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_w.ready) begin
      s1_v_r <= in_w.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_w.valid && in_w.ready) begin
      s1_chan_r   <= in_w.chan;
      s1_stamp_r  <= in_w.stamp[SB-1:0];
      s1_settle_r <= in_w.settle_count;
    end
  end

  // channel decode
  assign chan_ext = CX_W'(s1_chan_r);
  assign in_range = chan_ext < CX_W'(CHANNELS);
  assign idx      = chan_ext[IDX_W-1:0];
  assign cur_last = last_r[idx];
  assign cur_rise = rise_r[idx];

  generate
    if (CHANNELS > 1) begin : g_ch1
      assign ch1_width = last_r[1];
    end else begin : g_no_ch1
      assign ch1_width = '0;
    end
  endgenerate

  // remote check uses state from before this event
  assign claim = !remote_r && (ch1_width > cfg.activate_threshold) &&
                 (s1_settle_r >= cfg.settle_delay);

  rpc_width_calc #(.STAMP_W(SB)) u_calc (
    .fall_stamp  (s1_stamp_r),
    .rise_stamp  (cur_rise),
    .last_width  (cur_last),
    .wrap_period (cfg.wrap_period),
    .jump_limit  (cfg.jump_limit),
    .res         (calc)
  );

  // new stored width of the addressed channel
  always_comb begin
    fall_evt  = in_range && awaiting_r[idx];
    width_nxt = '0;
    if (in_range) begin
      width_nxt = (fall_evt && calc.accept) ? calc.width : cur_last;
    end
  end

  // per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        awaiting_r[i] <= 1'b0;
        rise_r[i]     <= '0;
        last_r[i]     <= WIDTH_RESET;
      end
      remote_r <= 1'b0;
    end else if (adv) begin
      if (in_range) begin
        if (awaiting_r[idx]) begin
          last_r[idx]     <= width_nxt;
          awaiting_r[idx] <= 1'b0;
        end else begin
          rise_r[idx]     <= s1_stamp_r;
          awaiting_r[idx] <= 1'b1;
        end
      end
      remote_r <= remote_r | claim;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_w.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r  <= s1_chan_r;
      out_wv_r    <= fall_evt;
      out_width_r <= width_nxt;
      out_on_r    <= remote_r | claim;
      out_claim_r <= claim;
    end
  end

  assign out_w.valid        = out_v_r;
  assign out_w.out_chan     = out_chan_r;
  assign out_w.width_valid  = out_wv_r;
  assign out_w.pulse_width  = out_width_r;
  assign out_w.remote_on    = out_on_r;
  assign out_w.remote_claim = out_claim_r;

  // a claim word always reports remote mode on
  a_claim_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_claim_r |-> out_on_r)
    else $error("remote_claim without remote_on");

  // remote mode never drops once latched
  a_remote_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    remote_r |=> remote_r)
    else $error("remote latch cleared");

  // a width result only comes from a channel that exists
  a_width_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_wv_r |-> (CX_W'(out_chan_r) < CX_W'(CHANNELS)))
    else $error("width result on missing channel");

  // input stalls only when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_w.ready |-> s1_v_r && out_v_r && !out_w.ready)
    else $error("input stalled without backpressure");

endmodule

// ===== sim/rc_pulse_width_capture_tb.sv =====
// Self-checking testbench for rc_pulse_width_capture: capture-event words in, decoded words out.
// Depends on rpc_pkg, rpc_ifs and the block's RTL; predicts each result word from its own model.
`timescale 1ns / 100ps

module rc_pulse_width_capture_tb;
  import rpc_pkg::*;

  localparam int NCH = CHANNELS_DEF;

  // Decoded word as it leaves the block
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic               width_valid;
    logic [FIELD_W-1:0] pulse_width;
    logic               remote_on;
    logic               remote_claim;
  } decoded_t;

  // Per-channel capture model plus the queue of decoded words still due
  class width_decoder_model;
    logic [WRAP_W-1:0]  wrap_period;
    logic [FIELD_W-1:0] jump_limit;
    logic [FIELD_W-1:0] activate_threshold;
    logic [FIELD_W-1:0] settle_delay;
    bit                 awaiting_fall[NCH];
    logic [FIELD_W-1:0] rise_stamp[NCH];
    logic [FIELD_W-1:0] last_width[NCH];
    bit                 remote_latch;
    decoded_t           due_words[$];
    int                 mismatches;

    function new();
      wrap_period        = WRAP_RESET;
      jump_limit         = JUMP_RESET;
      activate_threshold = THRESH_RESET;
      settle_delay       = SETTLE_RESET;
      for (int i = 0; i < NCH; i++) begin
        awaiting_fall[i] = 1'b0;
        rise_stamp[i]    = '0;
        last_width[i]    = WIDTH_RESET;
      end
      remote_latch = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_WRAP:   wrap_period        = value[WRAP_W-1:0];
        REG_JUMP:   jump_limit         = value[FIELD_W-1:0];
        REG_THRESH: activate_threshold = value[FIELD_W-1:0];
        REG_SETTLE: settle_delay       = value[FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DW-1:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_WRAP:   return APB_DW'(wrap_period);
        REG_JUMP:   return APB_DW'(jump_limit);
        REG_THRESH: return APB_DW'(activate_threshold);
        default:    return APB_DW'(settle_delay);
      endcase
    endfunction

    // One accepted capture event -> one decoded word
    function void predict_capture(logic [CHAN_W-1:0] ch, logic [FIELD_W-1:0] stamp,
                                  logic [FIELD_W-1:0] settle);
      decoded_t w;
      longint   width;
      longint   delta;
      w = '0;
      w.chan = ch;
      // remote check sees the channel-1 width from before this event
      if (!remote_latch && last_width[1] > activate_threshold && settle >= settle_delay) begin
        remote_latch   = 1'b1;
        w.remote_claim = 1'b1;
      end
      if (awaiting_fall[ch]) begin
        width = longint'(stamp) - longint'(rise_stamp[ch]);
        if (stamp < rise_stamp[ch])
          width += longint'(wrap_period);
        delta = width - longint'(last_width[ch]);
        if (delta < 0)
          delta = -delta;
        // glitch filter on the exact width, clamp only what gets stored
        if (delta <= longint'(jump_limit)) begin
          if (width < 0)
            width = 0;
          if (width > 65535)
            width = 65535;
          last_width[ch] = width[FIELD_W-1:0];
        end
        awaiting_fall[ch] = 1'b0;
        w.width_valid     = 1'b1;
      end else begin
        rise_stamp[ch]    = stamp;
        awaiting_fall[ch] = 1'b1;
      end
      w.pulse_width = last_width[ch];
      w.remote_on   = remote_latch;
      due_words.push_back(w);
    endfunction

    function void field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t ERROR %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void compare_word(decoded_t got);
      decoded_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t ERROR unexpected word: expected none, got chan %0d width %0d",
                   $time, got.chan, got.pulse_width);
        return;
      end
      want = due_words.pop_front();
      field_check("out_chan", want.chan, got.chan);
      field_check("width_valid", want.width_valid, got.width_valid);
      field_check("pulse_width", want.pulse_width, got.pulse_width);
      field_check("remote_on", want.remote_on, got.remote_on);
      field_check("remote_claim", want.remote_claim, got.remote_claim);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  rpc_in_if  in_w ();
  rpc_out_if out_w ();

  width_decoder_model model;

  // Sender burst/gap control and receiver stall style, set per phase
  bit tx_gaps;
  int burst_left;
  int rx_mode;
  int rx_hold;
  bit rx_state;
  int rx_cyc;

  rc_pulse_width_capture dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_w        (in_w),
    .out_w       (out_w),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL rc_pulse_width_capture");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_w.valid && out_w.ready)
      model.compare_word({out_w.out_chan, out_w.width_valid, out_w.pulse_width,
                          out_w.remote_on, out_w.remote_claim});
  end

  // Receiver back-pressure
  initial begin
    out_w.ready = 1'b0;
    rx_hold  = 0;
    rx_state = 1'b1;
    rx_cyc   = 0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      case (rx_mode)
        0: out_w.ready = 1'b1;
        1: out_w.ready = 1'($urandom_range(0, 1));
        2: out_w.ready = (rx_cyc % 5) < 3;
        default: begin
          // long stalls alternating with long ready stretches
          if (rx_hold == 0) begin
            rx_state = !rx_state;
            rx_hold  = rx_state ? $urandom_range(1, 10) : $urandom_range(1, 15);
          end
          rx_hold--;
          out_w.ready = rx_state;
        end
      endcase
    end
  end

  // Register write followed by a read-back; entered and left at a falling edge
  task automatic cfg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model.write_reg(idx, value);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    model.field_check("register read-back", model.reg_value(idx), rd);
  endtask

  // Send one capture word; returns at the falling edge after acceptance
  task automatic send_event(logic [CHAN_W-1:0] ch, logic [FIELD_W-1:0] stamp,
                            logic [FIELD_W-1:0] settle);
    if (tx_gaps && burst_left == 0) begin
      in_w.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0)
      burst_left--;
    in_w.chan         = ch;
    in_w.stamp        = stamp;
    in_w.settle_count = settle;
    in_w.valid        = 1'b1;
    do @(posedge clk); while (!in_w.ready);
    model.predict_capture(ch, stamp, settle);
    @(negedge clk);
    in_w.valid = 1'b0;
  endtask

  // Full pulse on one channel; a pending fall is closed first so the rise lands
  task automatic pulse(logic [CHAN_W-1:0] ch, logic [FIELD_W-1:0] rise,
                       logic [FIELD_W-1:0] fall, logic [FIELD_W-1:0] settle);
    if (model.awaiting_fall[ch])
      send_event(ch, rise, settle);
    send_event(ch, rise, settle);
    send_event(ch, fall, settle);
  endtask

  // Mostly plausible edges aimed near the filter window, the rest noise
  task automatic random_event();
    logic [CHAN_W-1:0]  ch;
    logic [FIELD_W-1:0] settle;
    logic [FIELD_W-1:0] stamp;
    int                 j;
    int                 w;
    int                 fall;
    ch = CHAN_W'($urandom_range(0, NCH - 1));
    case ($urandom_range(0, 5))
      0: settle = model.settle_delay;
      1: settle = model.settle_delay - 16'd1;
      2: settle = '0;
      3: settle = '1;
      default: settle = FIELD_W'($urandom);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      stamp = FIELD_W'($urandom);
    end else if (model.awaiting_fall[ch]) begin
      j = int'(model.jump_limit);
      w = int'(model.last_width[ch]) + int'($urandom_range(0, 2 * j)) - j;
      // occasionally just outside the accepted window
      if ($urandom_range(0, 4) == 0)
        w = int'(model.last_width[ch]) + ($urandom_range(0, 1) ? 1 : -1) *
            (j + int'($urandom_range(1, 50)));
      if (w < 0)
        w = 0;
      if (w > 65535)
        w = 65535;
      fall = int'(model.rise_stamp[ch]) + w;
      if (fall > 65535)
        fall -= int'(model.wrap_period);
      stamp = fall[FIELD_W-1:0];
    end else if (model.wrap_period > 1 && model.wrap_period <= 65536 &&
                 $urandom_range(0, 1)) begin
      stamp = FIELD_W'($urandom_range(0, int'(model.wrap_period) - 1));
    end else begin
      stamp = FIELD_W'($urandom);
    end
    send_event(ch, stamp, settle);
  endtask

  // Let every due word come out, plus the block's latency
  task automatic wait_drained();
    while (model.due_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers and handshake behavior per phase
  task automatic apply_phase(int p);
    case (p)
      0: begin
        rx_mode = 0;
        tx_gaps = 1'b0;
      end
      1: begin
        cfg_write(REG_WRAP, 32'd65536);
        cfg_write(REG_JUMP, 32'd65535);
        cfg_write(REG_THRESH, 32'd0);
        cfg_write(REG_SETTLE, 32'd65535);
        rx_mode = 1;
        tx_gaps = 1'b1;
      end
      2: begin
        cfg_write(REG_WRAP, 32'd1);
        cfg_write(REG_JUMP, 32'd65535);
        cfg_write(REG_THRESH, 32'd65535);
        cfg_write(REG_SETTLE, 32'd0);
        rx_mode = 2;
        tx_gaps = 1'b1;
      end
      3: begin
        cfg_write(REG_WRAP, 32'd0);
        cfg_write(REG_JUMP, 32'd0);
        cfg_write(REG_SETTLE, 32'd100);
        rx_mode = 3;
        tx_gaps = 1'b1;
      end
      4: begin
        cfg_write(REG_WRAP, 32'h1FFFF);
        cfg_write(REG_JUMP, 32'd65535);
        cfg_write(REG_THRESH, 32'd1);
        cfg_write(REG_SETTLE, 32'd1);
        rx_mode = 1;
        tx_gaps = 1'b0;
      end
      default: begin
        cfg_write(REG_WRAP, $urandom_range(1, 65536));
        cfg_write(REG_JUMP, $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom);
        cfg_write(REG_THRESH, $urandom);
        cfg_write(REG_SETTLE, $urandom);
        rx_mode = int'($urandom_range(0, 3));
        tx_gaps = 1'($urandom_range(0, 1));
      end
    endcase
  endtask

  task automatic run_directed(int p);
    case (p)
      0: begin
        pulse(0, 16'd0, 16'd1500, 16'd0);         // exact width, no wrap
        pulse(0, 16'd9000, 16'd500, 16'd0);       // counter wrap
        pulse(3, 16'd0, 16'd2001, 16'hFFFF);      // one past the jump limit
        pulse(3, 16'd100, 16'd2100, 16'd0);       // exactly at the jump limit
        pulse(2, 16'hFFFF, 16'hFFFF, 16'd0);      // zero width, rejected
        pulse(1, 16'd100, 16'd1900, 16'd12345);   // channel 1 above threshold
        pulse(2, 16'd4660, 16'd6160, 16'hFFFF);   // remote claim on the rise
      end
      2: begin
        pulse(0, 16'd100, 16'd50, 16'd0);         // negative width stored as zero
        pulse(0, 16'd0, 16'hFFFF, 16'd0);
      end
      3: pulse(1, 16'd10, 16'd5, 16'd0);          // wrap of zero adds nothing
      4: begin
        pulse(0, 16'd0, 16'hFFFF, 16'd0);
        pulse(0, 16'hFFFF, 16'hFFFE, 16'd0);      // width above 16 bits saturates
      end
      default: ;
    endcase
  endtask

  initial begin
    model = new();
    rst_n             = 1'b0;
    in_w.valid        = 1'b0;
    in_w.chan         = '0;
    in_w.stamp        = '0;
    in_w.settle_count = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    tx_gaps           = 1'b0;
    burst_left        = 0;
    rx_mode           = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int p = 0; p < 8; p++) begin
      // registers only change with nothing in flight
      wait_drained();
      apply_phase(p);
      run_directed(p);
      repeat (50) random_event();
    end

    while (model.due_words.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (model.mismatches == 0 && model.due_words.size() == 0) begin
      $display("PASS rc_pulse_width_capture");
    end else begin
      $display("FAIL rc_pulse_width_capture");
    end
    $finish;
  end

endmodule
